[sv/orsb_pkg.sv]
// shared types and constants for the overwrite ring sample buffer
// no dependencies; used by the interfaces, controller, datapath and top level
`timescale 1ns / 1ps

package orsb_pkg;

  localparam int OP_W   = 3;
  localparam int REQ_W  = 7;
  localparam int CNT_W  = 11;
  localparam int DATA_W = 32;

  localparam logic [OP_W-1:0] OP_PUSH   = 3'd0;
  localparam logic [OP_W-1:0] OP_POP    = 3'd1;
  localparam logic [OP_W-1:0] OP_LATEST = 3'd2;
  localparam logic [OP_W-1:0] OP_CLEAR  = 3'd3;
  localparam logic [OP_W-1:0] OP_STATUS = 3'd4;

  typedef enum logic {
    ST_IDLE,
    ST_BURST
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic push;
    logic clear;
    logic cfg_write;
    logic single;
    logic single_status;
    logic start_pop;
    logic start_latest;
    logic beat;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic out_free;
    logic empty;
    logic n_zero;
    logic last_beat;
  } stat_t;

endpackage

[sv/orsb_if.sv]
// channel interfaces: request, result and capacity write
// depends on orsb_pkg
`timescale 1ns / 1ps

interface orsb_req_if;
  logic                         valid;
  logic                         ready;
  logic [orsb_pkg::OP_W-1:0]    opcode;
  logic [orsb_pkg::DATA_W-1:0]  sample_in;
  logic [orsb_pkg::REQ_W-1:0]   request_count;

  modport source (output valid, opcode, sample_in, request_count, input ready);
  modport sink (input valid, opcode, sample_in, request_count, output ready);
endinterface

interface orsb_rsp_if;
  logic                         valid;
  logic                         ready;
  logic [orsb_pkg::DATA_W-1:0]  sample_out;
  logic                         sample_valid;
  logic                         last_of_run;
  logic                         status;
  logic [orsb_pkg::CNT_W-1:0]   fill_level;

  modport source (output valid, sample_out, sample_valid, last_of_run, status, fill_level,
                  input ready);
  modport sink (input valid, sample_out, sample_valid, last_of_run, status, fill_level,
                output ready);
endinterface

interface orsb_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [orsb_pkg::CNT_W-1:0]   data;

  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

[sv/overwrite_ring_sample_buffer.sv]
// overwrite ring sample buffer: push one transfer per cycle while idle with a free
// result register, no result; pop or latest of n samples: n results, the request
// loads the burst walker, then one per cycle into the result register while the
// result side takes them; status and empty or zero requests: one result, valid the
// cycle after the request; reset clears positions and fill count, capacity 1024
// clamped to DEPTH; sample memory contents are not cleared
`timescale 1ns / 1ps

module overwrite_ring_sample_buffer #(
  parameter int DEPTH       = 1024,
  parameter int MAX_BURST   = 64,
  parameter int SAMPLE_BITS = 32
) (
  input  logic  clk,
  input  logic  rst,
  orsb_req_if.sink   req,
  orsb_rsp_if.source rsp,
  orsb_cfg_if.sink   cfg
);

  orsb_pkg::cmd_t  cmd;
  orsb_pkg::stat_t stat;

  orsb_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .opcode    (req.opcode),
    .req_ready (req.ready),
    .cfg_valid (cfg.valid),
    .cfg_ready (cfg.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  orsb_dp #(
    .DEPTH       (DEPTH),
    .MAX_BURST   (MAX_BURST),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .stat          (stat),
    .sample_in     (req.sample_in),
    .request_count (req.request_count),
    .cfg_data      (cfg.data),
    .rsp_ready     (rsp.ready),
    .rsp_valid     (rsp.valid),
    .sample_out    (rsp.sample_out),
    .sample_valid  (rsp.sample_valid),
    .last_of_run   (rsp.last_of_run),
    .status        (rsp.status),
    .fill_level    (rsp.fill_level)
  );

endmodule

[sv/orsb_ctrl.sv]
// request sequencer: decodes opcodes and steps read bursts
// depends on orsb_pkg
`timescale 1ns / 1ps

module orsb_ctrl (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        req_valid,
  input  logic [orsb_pkg::OP_W-1:0]   opcode,
  output logic                        req_ready,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  orsb_pkg::stat_t             stat,
  output orsb_pkg::cmd_t              cmd
);

  orsb_pkg::state_t state;
  orsb_pkg::state_t state_next;
  logic             take;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= orsb_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    req_ready  = 1'b0;
    cfg_ready  = 1'b0;
    take       = 1'b0;
    case (state)
      orsb_pkg::ST_IDLE: begin
        req_ready     = stat.out_free;
        cfg_ready     = 1'b1;
        cmd.cfg_write = cfg_valid;
        take          = req_valid && stat.out_free;
        if (take) begin
          case (opcode)
            orsb_pkg::OP_PUSH:  cmd.push = 1'b1;
            orsb_pkg::OP_CLEAR: cmd.clear = 1'b1;
            orsb_pkg::OP_STATUS: cmd.single = 1'b1;
            orsb_pkg::OP_POP: begin
              if (stat.empty) begin
                cmd.single        = 1'b1;
                cmd.single_status = 1'b1;
              end else if (stat.n_zero) begin
                cmd.single = 1'b1;
              end else begin
                cmd.start_pop = 1'b1;
                state_next    = orsb_pkg::ST_BURST;
              end
            end
            orsb_pkg::OP_LATEST: begin
              if (stat.n_zero) begin
                cmd.single = 1'b1;
              end else begin
                cmd.start_latest = 1'b1;
                state_next       = orsb_pkg::ST_BURST;
              end
            end
            default: ;
          endcase
        end
      end
      orsb_pkg::ST_BURST: begin
        if (stat.out_free) begin
          cmd.beat = 1'b1;
          if (stat.last_beat) begin
            state_next = orsb_pkg::ST_IDLE;
          end
        end
      end
      default: state_next = orsb_pkg::ST_IDLE;
    endcase
  end

endmodule

[sv/orsb_dp.sv]
// datapath: sample memory, ring positions, fill count, burst walker, result register
// depends on orsb_pkg
`timescale 1ns / 1ps

module orsb_dp #(
  parameter int DEPTH       = 1024,
  parameter int MAX_BURST   = 64,
  parameter int SAMPLE_BITS = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  input  orsb_pkg::cmd_t                cmd,
  output orsb_pkg::stat_t               stat,
  input  logic [orsb_pkg::DATA_W-1:0]   sample_in,
  input  logic [orsb_pkg::REQ_W-1:0]    request_count,
  input  logic [orsb_pkg::CNT_W-1:0]    cfg_data,
  input  logic                          rsp_ready,
  output logic                          rsp_valid,
  output logic [orsb_pkg::DATA_W-1:0]   sample_out,
  output logic                          sample_valid,
  output logic                          last_of_run,
  output logic                          status,
  output logic [orsb_pkg::CNT_W-1:0]    fill_level
);

  localparam int CW      = orsb_pkg::CNT_W;
  localparam int RW      = orsb_pkg::REQ_W;
  localparam int AW      = $clog2(DEPTH);
  localparam int XW      = (AW + 1 > CW) ? AW + 1 : CW;
  localparam int RST_CAP = (DEPTH < 1024) ? DEPTH : 1024;

  logic [SAMPLE_BITS-1:0] mem [DEPTH];
  logic [SAMPLE_BITS-1:0] mem_q;

  logic [CW-1:0] cap;
  logic [AW-1:0] wr_idx;
  logic [AW-1:0] rd_idx;
  logic [CW-1:0] count;
  logic [AW-1:0] pos;
  logic [RW-1:0] remain;
  logic [CW-1:0] burst_fill;

  logic          out_valid;
  logic          out_flag;
  logic          out_last;
  logic          out_status;
  logic [CW-1:0] out_fill;

  logic [RW-1:0] req_sat;
  logic [CW-1:0] n;
  logic [XW-1:0] cap_x;
  logic [XW-1:0] n_x;
  logic [XW-1:0] wr_x;
  logic [XW-1:0] rd_sum;
  logic [XW-1:0] win_start;
  logic [CW-1:0] cap_next;
  logic [63:0]   wide_in;
  logic [63:0]   wide_out;

  function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] idx,
                                             input logic [XW-1:0] lim);
    logic [XW-1:0] s;
    s = XW'(idx) + XW'(1);
    return (s == lim) ? '0 : s[AW-1:0];
  endfunction

  always_comb begin
    req_sat  = (request_count > RW'(MAX_BURST)) ? RW'(MAX_BURST) : request_count;
    n        = (CW'(req_sat) < count) ? CW'(req_sat) : count;
    cap_x    = XW'(cap);
    n_x      = XW'(n);
    wr_x     = XW'(wr_idx);
    rd_sum   = XW'(rd_idx) + n_x;
    if (rd_sum >= cap_x) begin
      rd_sum = rd_sum - cap_x;
    end
    // window of the newest n samples, wrapping below zero
    if (wr_x >= n_x) begin
      win_start = wr_x - n_x;
    end else begin
      win_start = wr_x + cap_x - n_x;
    end
    if (cfg_data == '0) begin
      cap_next = CW'(1);
    end else if (XW'(cfg_data) > XW'(DEPTH)) begin
      cap_next = CW'(DEPTH);
    end else begin
      cap_next = cfg_data;
    end
    wide_in  = 64'(sample_in);
    wide_out = 64'(mem_q);
  end

  // ring positions and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      cap    <= CW'(RST_CAP);
      wr_idx <= '0;
      rd_idx <= '0;
      count  <= '0;
    end else if (cmd.cfg_write) begin
      cap    <= cap_next;
      wr_idx <= '0;
      rd_idx <= '0;
      count  <= '0;
    end else if (cmd.clear) begin
      wr_idx <= '0;
      rd_idx <= '0;
      count  <= '0;
    end else if (cmd.push) begin
      wr_idx <= wrap_inc(wr_idx, cap_x);
      if (count < cap) begin
        count <= count + CW'(1);
      end else begin
        rd_idx <= wrap_inc(rd_idx, cap_x);
      end
    end else if (cmd.start_pop) begin
      rd_idx <= rd_sum[AW-1:0];
      count  <= count - n;
    end
  end

  // burst walker
  always_ff @(posedge clk) begin
    if (rst) begin
      remain <= '0;
    end else if (cmd.start_pop || cmd.start_latest) begin
      remain <= RW'(n);
    end else if (cmd.beat) begin
      remain <= remain - RW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start_pop) begin
      pos        <= rd_idx;
      burst_fill <= count - n;
    end else if (cmd.start_latest) begin
      pos        <= win_start[AW-1:0];
      burst_fill <= count;
    end else if (cmd.beat) begin
      pos <= wrap_inc(pos, cap_x);
    end
  end

  // sample memory, read data held while the result stalls
  always_ff @(posedge clk) begin
    if (cmd.push) begin
      mem[wr_idx] <= wide_in[SAMPLE_BITS-1:0];
    end
    if (cmd.beat) begin
      mem_q <= mem[pos];
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.single || cmd.beat) begin
      out_valid <= 1'b1;
    end else if (rsp_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.single) begin
      out_flag   <= 1'b0;
      out_last   <= 1'b1;
      out_status <= cmd.single_status;
      out_fill   <= count;
    end else if (cmd.beat) begin
      out_flag   <= 1'b1;
      out_last   <= (remain == RW'(1));
      out_status <= 1'b0;
      out_fill   <= burst_fill;
    end
  end

  assign rsp_valid    = out_valid;
  assign sample_out   = out_flag ? wide_out[orsb_pkg::DATA_W-1:0] : '0;
  assign sample_valid = out_flag;
  assign last_of_run  = out_last;
  assign status       = out_status;
  assign fill_level   = out_fill;

  assign stat.out_free  = !out_valid || rsp_ready;
  assign stat.empty     = (count == '0);
  assign stat.n_zero    = (n == '0);
  assign stat.last_beat = (remain == RW'(1));

endmodule

[tb/sv/tb_overwrite_ring_sample_buffer.sv]
// self-checking testbench for overwrite_ring_sample_buffer: ring mirror scoreboard,
// request/result/capacity drivers, random gaps, long result-side hold-off, watchdog
// depends on orsb_pkg, orsb_if and the overwrite_ring_sample_buffer rtl
`timescale 1ns / 1ps

module tb_overwrite_ring_sample_buffer;

  localparam int DEPTH         = 1024;
  localparam int MAX_BURST     = 64;
  localparam int SAMPLE_BITS   = 32;
  localparam int AW            = $clog2(DEPTH);
  localparam int CLK_PERIOD    = 10;
  localparam int GAP_PCT       = 16;
  localparam int HOLD_CYCLES   = 250;
  localparam int SETTLE_CYCLES = 8;
  localparam int STALL_LIMIT   = 3000;
  localparam int MAX_PRINTS    = 30;

  typedef logic [orsb_pkg::OP_W-1:0]   op_t;
  typedef logic [orsb_pkg::DATA_W-1:0] data_t;
  typedef logic [orsb_pkg::REQ_W-1:0]  cnt_t;
  typedef logic [orsb_pkg::CNT_W-1:0]  fill_t;

  // opcodes the block must ignore
  localparam op_t OP_RSVD5 = 3'd5;
  localparam op_t OP_RSVD6 = 3'd6;
  localparam op_t OP_RSVD7 = 3'd7;

  typedef struct packed {
    data_t sample;
    logic  valid;
    logic  last;
    logic  status;
    fill_t fill;
  } result_t;

  class sample_ring_mirror;
    data_t       samples [DEPTH];
    int unsigned wr_ptr;
    int unsigned rd_ptr;
    int unsigned level;
    int unsigned cap_raw;
    result_t     pending_results[$];
    int unsigned requests;
    int unsigned checked;
    int unsigned mismatches;

    function new();
      cap_raw = DEPTH;
      wr_ptr  = 0;
      rd_ptr  = 0;
      level   = 0;
    endfunction

    function int unsigned eff_cap();
      if (cap_raw == 0) return 1;
      if (cap_raw > DEPTH) return DEPTH;
      return cap_raw;
    endfunction

    function int unsigned next_pos(int unsigned p);
      return (p + 1 == eff_cap()) ? 0 : p + 1;
    endfunction

    function void expect_result(data_t s, logic v, logic l, logic st, int unsigned fill);
      result_t r;
      r.sample = s;
      r.valid  = v;
      r.last   = l;
      r.status = st;
      r.fill   = fill[orsb_pkg::CNT_W-1:0];
      pending_results.push_back(r);
    endfunction

    // a capacity write also empties the ring
    function void set_capacity(fill_t v);
      cap_raw = 32'(v);
      wr_ptr  = 0;
      rd_ptr  = 0;
      level   = 0;
    endfunction

    function void note_request(op_t op, data_t s, cnt_t cnt);
      int unsigned cap;
      int unsigned want;
      int unsigned n;
      int unsigned pos;
      cap  = eff_cap();
      want = (cnt > MAX_BURST) ? MAX_BURST : 32'(cnt);
      n    = (want < level) ? want : level;
      requests++;
      case (op)
        orsb_pkg::OP_PUSH: begin
          samples[wr_ptr[AW-1:0]] = s;
          wr_ptr = next_pos(wr_ptr);
          if (level < cap) level++;
          else rd_ptr = next_pos(rd_ptr);
        end
        orsb_pkg::OP_POP: begin
          if (level == 0) begin
            expect_result('0, 1'b0, 1'b1, 1'b1, 0);
          end else if (n == 0) begin
            expect_result('0, 1'b0, 1'b1, 1'b0, level);
          end else begin
            for (int i = 0; i < n; i++) begin
              expect_result(samples[rd_ptr[AW-1:0]], 1'b1, i + 1 == n, 1'b0, level - n);
              rd_ptr = next_pos(rd_ptr);
            end
            level -= n;
          end
        end
        orsb_pkg::OP_LATEST: begin
          if (n == 0) begin
            expect_result('0, 1'b0, 1'b1, 1'b0, level);
          end else begin
            pos = (wr_ptr + cap - n) % cap;
            for (int i = 0; i < n; i++) begin
              expect_result(samples[pos[AW-1:0]], 1'b1, i + 1 == n, 1'b0, level);
              pos = next_pos(pos);
            end
          end
        end
        orsb_pkg::OP_CLEAR: begin
          wr_ptr = 0;
          rd_ptr = 0;
          level  = 0;
        end
        orsb_pkg::OP_STATUS: expect_result('0, 1'b0, 1'b1, 1'b0, level);
        default: ;
      endcase
    endfunction

    task report(string msg);
      mismatches++;
      if (mismatches <= MAX_PRINTS) $display("MISMATCH @%0t: %s", $realtime, msg);
    endtask

    task check_result(result_t got);
      result_t want;
      checked++;
      if (pending_results.size() == 0) begin
        report($sformatf("unexpected result data %h valid %b last %b status %b fill %0d",
                         got.sample, got.valid, got.last, got.status, got.fill));
        return;
      end
      want = pending_results.pop_front();
      if (got.sample !== want.sample || got.valid !== want.valid ||
          got.last !== want.last || got.status !== want.status || got.fill !== want.fill)
        report($sformatf("got data %h v%b l%b s%b fill %0d, expected %h v%b l%b s%b fill %0d",
                         got.sample, got.valid, got.last, got.status, got.fill,
                         want.sample, want.valid, want.last, want.status, want.fill));
    endtask
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;

  bit          no_gaps;
  bit          hold_ready;
  int unsigned cap_writes;
  int unsigned holds_done;
  sample_ring_mirror ring;

  orsb_req_if req_ch();
  orsb_rsp_if rsp_ch();
  orsb_cfg_if cfg_ch();

  overwrite_ring_sample_buffer #(
    .DEPTH      (DEPTH),
    .MAX_BURST  (MAX_BURST),
    .SAMPLE_BITS(SAMPLE_BITS)
  ) i_dut (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .rsp(rsp_ch),
    .cfg(cfg_ch)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  function int gap_pct();
    return no_gaps ? 0 : GAP_PCT;
  endfunction

  task send_request(op_t op, data_t s, cnt_t cnt);
    while ($urandom_range(99) < gap_pct()) begin
      req_ch.valid <= 1'b0;
      @(negedge clk);
    end
    req_ch.valid         <= 1'b1;
    req_ch.opcode        <= op;
    req_ch.sample_in     <= s;
    req_ch.request_count <= cnt;
    do @(posedge clk); while (req_ch.ready !== 1'b1);
    ring.note_request(op, s, cnt);
    @(negedge clk);
  endtask

  task write_capacity(fill_t v);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= v;
    do @(posedge clk); while (cfg_ch.ready !== 1'b1);
    ring.set_capacity(v);
    cap_writes++;
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
    @(negedge clk);
  endtask

  // let every expected result arrive, then cover pushes and clears still in flight
  task drain();
    req_ch.valid <= 1'b0;
    @(negedge clk);
    while (ring.pending_results.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // mostly pushes and reads so the ring fills, wraps and overwrites
  task run_random(int unsigned n_items);
    int unsigned done;
    int unsigned pick;
    int unsigned r;
    op_t         op;
    cnt_t        cnt;
    done = 0;
    while (done < n_items) begin
      pick = $urandom_range(99);
      if (pick < 52) op = orsb_pkg::OP_PUSH;
      else if (pick < 68) op = orsb_pkg::OP_POP;
      else if (pick < 82) op = orsb_pkg::OP_LATEST;
      else if (pick < 89) op = orsb_pkg::OP_STATUS;
      else if (pick < 94) op = orsb_pkg::OP_CLEAR;
      else begin
        case ($urandom_range(2))
          0: op = OP_RSVD5;
          1: op = OP_RSVD6;
          default: op = OP_RSVD7;
        endcase
      end
      r = $urandom_range(99);
      if (r < 65) cnt = cnt_t'($urandom_range(0, 8));
      else if (r < 90) cnt = cnt_t'($urandom_range(0, MAX_BURST));
      else cnt = cnt_t'($urandom_range(MAX_BURST + 1, 127));
      send_request(op, $urandom(), cnt);
      if (op != OP_RSVD5 && op != OP_RSVD6 && op != OP_RSVD7) done++;
    end
  endtask

  // result side: random back-pressure plus an occasional long hold-off
  initial begin
    rsp_ch.ready = 1'b0;
    @(negedge clk);
    forever begin
      if (hold_ready) begin
        rsp_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_ready = 1'b0;
        holds_done++;
      end
      rsp_ch.ready <= ($urandom_range(99) < gap_pct()) ? 1'b0 : 1'b1;
      @(negedge clk);
    end
  end

  always @(posedge clk) begin
    result_t got;
    if (!rst && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
      got.sample = rsp_ch.sample_out;
      got.valid  = rsp_ch.sample_valid;
      got.last   = rsp_ch.last_of_run;
      got.status = rsp_ch.status;
      got.fill   = rsp_ch.fill_level;
      ring.check_result(got);
    end
  end

  initial begin
    int unsigned stall;
    stall = 0;
    while (stall < STALL_LIMIT) begin
      @(posedge clk);
      if ((req_ch.valid === 1'b1 && req_ch.ready === 1'b1) ||
          (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) ||
          (cfg_ch.valid === 1'b1 && cfg_ch.ready === 1'b1))
        stall = 0;
      else
        stall++;
    end
    $display("watchdog: no transfer for %0d cycles", STALL_LIMIT);
    $display("tb_overwrite_ring_sample_buffer: FAIL");
    $finish;
  end

  initial begin
    ring = new();
    req_ch.valid         = 1'b0;
    req_ch.opcode        = orsb_pkg::OP_PUSH;
    req_ch.sample_in     = '0;
    req_ch.request_count = '0;
    cfg_ch.valid         = 1'b0;
    cfg_ch.data          = '0;
    no_gaps    = 1'b0;
    hold_ready = 1'b0;
    cap_writes = 0;
    holds_done = 0;
    repeat (9) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed: empty cases, zero and saturated requests, ignored opcodes, clear
    send_request(orsb_pkg::OP_STATUS, '0, 7'd0);
    send_request(orsb_pkg::OP_POP, '0, 7'd5);
    send_request(orsb_pkg::OP_LATEST, '0, 7'd3);
    send_request(orsb_pkg::OP_PUSH, 32'h0000_0000, 7'd0);
    send_request(orsb_pkg::OP_PUSH, 32'hffff_ffff, 7'd127);
    send_request(orsb_pkg::OP_PUSH, 32'ha5a5_a5a5, 7'd0);
    send_request(orsb_pkg::OP_PUSH, 32'h5a5a_5a5a, 7'd0);
    send_request(orsb_pkg::OP_POP, '0, 7'd0);
    send_request(orsb_pkg::OP_LATEST, '0, 7'd0);
    send_request(orsb_pkg::OP_LATEST, 32'hffff_ffff, 7'd127);
    send_request(orsb_pkg::OP_LATEST, '0, 7'd2);
    send_request(orsb_pkg::OP_POP, '0, 7'd1);
    send_request(orsb_pkg::OP_STATUS, '0, 7'd0);
    send_request(OP_RSVD5, 32'h1234_5678, 7'd4);
    send_request(OP_RSVD6, 32'h8765_4321, 7'd4);
    send_request(OP_RSVD7, 32'hffff_ffff, 7'd127);
    send_request(orsb_pkg::OP_POP, '0, 7'd64);
    send_request(orsb_pkg::OP_POP, '0, 7'd1);
    send_request(orsb_pkg::OP_PUSH, 32'hdead_beef, 7'd0);
    send_request(orsb_pkg::OP_PUSH, 32'h0bad_f00d, 7'd0);
    send_request(orsb_pkg::OP_CLEAR, '0, 7'd0);
    send_request(orsb_pkg::OP_STATUS, '0, 7'd0);
    send_request(orsb_pkg::OP_LATEST, '0, 7'd64);
    drain();

    // capacity zero behaves as one
    write_capacity(11'd0);
    run_random(40);
    drain();

    // small ring with the result side held off so the input stalls
    write_capacity(11'd5);
    hold_ready = 1'b1;
    repeat (2) @(negedge clk);
    run_random(60);
    drain();

    // back-to-back transfers, no gaps on either side
    write_capacity(11'd37);
    no_gaps = 1'b1;
    run_random(90);
    drain();
    no_gaps = 1'b0;

    // above depth clamps to depth
    write_capacity(11'd2047);
    run_random(50);
    drain();

    write_capacity(11'd1);
    run_random(30);
    drain();

    write_capacity(11'd1024);
    run_random(56);
    drain();

    $display("covered %0d requests over %0d capacity settings, %0d long result hold-off(s)",
             ring.requests, cap_writes + 1, holds_done);
    $display("%0d results checked, %0d mismatches", ring.checked, ring.mismatches);
    if (ring.mismatches == 0) begin
      $display("tb_overwrite_ring_sample_buffer: PASS");
    end else begin
      $display("tb_overwrite_ring_sample_buffer: FAIL");
    end
    $finish;
  end

endmodule
